### design/rcfp_pkg.sv
// ============================================================================
// rcfp_pkg - shared types and constants of the command frame parser
// Item structs, divider status, sequencer states and setting limits.
// ============================================================================
package rcfp_pkg;

    // ASCII codes seen by the frame scanner
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_L      = 8'h4C;

    localparam int GNSS_W  = 15;
    localparam int WAVE_W  = 16;
    localparam int FIX_W   = 8;
    localparam int VAL_W   = 7;   // two decimal digits
    localparam int QUO_W   = 5;   // 21600 / 900 = 24 fits

    localparam logic [GNSS_W-1:0] GNSS_MAX_S  = GNSS_W'(6 * 60 * 60);
    localparam logic [GNSS_W-1:0] GNSS_MIN_S  = GNSS_W'(15 * 60);
    localparam logic [GNSS_W-1:0] GNSS_STEP_S = GNSS_W'(15 * 60);
    localparam logic [WAVE_W-1:0] WAVE_STEP_S = WAVE_W'(30 * 60);
    localparam logic [VAL_W-1:0]  GNSS_VMAX   = VAL_W'(6 * 4);
    localparam logic [VAL_W-1:0]  WAVE_VMAX   = VAL_W'(12 * 2);

    localparam logic [GNSS_W-1:0] GNSS_RST    = GNSS_W'(3600);
    localparam logic [WAVE_W-1:0] WAVE_RST    = WAVE_W'(10800);
    localparam logic [WAVE_W-1:0] THERM_RST   = WAVE_W'(3600);
    localparam logic [FIX_W-1:0]  MINFIX_RST  = FIX_W'(1);
    localparam logic [FIX_W-1:0]  MAXFIX_RST  = FIX_W'(35);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [GNSS_W-1:0] gnss_interval_s;
        logic [FIX_W-1:0]  min_fixes_per_message;
        logic [WAVE_W-1:0] wave_interval_s;
        logic [WAVE_W-1:0] thermistor_interval_s;
        logic              reboot_request;
    } set_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

### design/remote_command_frame_parser.sv
// ============================================================================
// remote_command_frame_parser - downlink command frame parser
// Scans received message bytes for "$LLLvv;" frames and emits settings.
// ============================================================================
// Usage notes:
//  - cmd channel: one message byte per item plus a last-byte mark.
//    Ordinary bytes are taken without a stall; cmd_ready stays high.
//  - On the last byte of a message the settings are clamped. The minimum
//    fix count needs 21600 / gnss interval, done by the restoring divider
//    one quotient bit a cycle. On its way to set_valid a last byte passes
//    prep, 5 divide steps, the done flag, the result state (held until the
//    output register is free) and that register; cmd_ready is low meanwhile.
//  - set channel: one settings item per message, held in an output
//    register. Further bytes of the next message are still taken while it
//    waits; a following last byte parks in the result state until the
//    receiver takes the earlier item.
//  - cfg channel: max_fixes_per_message, always ready; write it only while
//    the block is idle.
//  - Reset: window empty, BOOT prefix armed, settings at their defaults
//    (3600 s, 10800 s, 3600 s, 1 fix), max fixes 35, no item pending.
// ============================================================================
module remote_command_frame_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  rcfp_pkg::cmd_item_t cmd_item,
    output logic                set_valid,
    input  logic                set_ready,
    output rcfp_pkg::set_item_t set_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    localparam int GW = rcfp_pkg::GNSS_W;
    localparam int WW = rcfp_pkg::WAVE_W;
    localparam int FW = rcfp_pkg::FIX_W;
    localparam int VW = rcfp_pkg::VAL_W;
    localparam int QW = rcfp_pkg::QUO_W;

    // ---------------------------------------------------------------------
    // Character helpers
    // ---------------------------------------------------------------------
    function automatic logic is_dig(input logic [7:0] c);
        return (c >= rcfp_pkg::CH_ZERO) && (c <= rcfp_pkg::CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == rcfp_pkg::CH_SPACE) ||
               ((c >= rcfp_pkg::CH_TAB) && (c <= rcfp_pkg::CH_CR));
    endfunction

    function automatic logic [3:0] dig_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - rcfp_pkg::CH_ZERO;
        return d[3:0];
    endfunction

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    rcfp_pkg::state_t state_reg, state_next;

    logic [7:0]    win_reg [6];           // bytes 0..5 of the 7-byte window
    logic [2:0]    fill_reg,   fill_next;
    logic [2:0]    prefix_reg, prefix_next;
    logic          boot_ok_reg, boot_ok_next;
    logic          reboot_reg, reboot_next;

    logic [GW-1:0] gnss_reg,  gnss_next;
    logic [WW-1:0] wave_reg,  wave_next;
    logic [WW-1:0] therm_reg, therm_next;
    logic [FW-1:0] minfix_reg, minfix_next;
    logic [FW-1:0] maxfix_reg;

    logic                set_valid_reg, set_valid_next;
    rcfp_pkg::set_item_t set_item_reg,  set_item_next;

    logic                cmd_fire;
    logic [7:0]          bt;

    // frame decode
    logic [7:0]    c0, c1;
    logic          frame_hit;
    logic          val_neg;
    logic [VW-1:0] val;
    logic [GW-1:0] gnss_set;
    logic [WW-1:0] wave_set;

    // clamp path
    logic [GW-1:0] gnss_clamped;
    logic [FW-1:0] minfix_m1, minfix_m2;
    logic          out_free;

    // divider
    logic                div_start;
    logic [QW-1:0]       div_quot;
    rcfp_pkg::div_stat_t div_stat;

    assign cmd_ready = (state_reg == rcfp_pkg::ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign bt        = cmd_item.rx_byte;
    assign cfg_ready = 1'b1;
    assign out_free  = !set_valid_reg || set_ready;

    // A frame closes when six bytes are held and the new one completes it
    assign c0        = win_reg[4];
    assign c1        = win_reg[5];
    assign frame_hit = (fill_reg == 3'd6) && (win_reg[0] == rcfp_pkg::CH_DOLLAR) &&
                       (bt == rcfp_pkg::CH_SEMI);

    // two-character atoi
    always_comb
    begin
        val     = '0;
        val_neg = 1'b0;
        if (is_dig(c0))
        begin
            if (is_dig(c1))
                val = VW'(dig_val(c0)) * VW'(10) + VW'(dig_val(c1));
            else
                val = VW'(dig_val(c0));
        end
        else if ((c0 == rcfp_pkg::CH_PLUS) || (c0 == rcfp_pkg::CH_MINUS) || is_ws(c0))
        begin
            if (is_dig(c1))
            begin
                val     = VW'(dig_val(c1));
                val_neg = (c0 == rcfp_pkg::CH_MINUS) && (c1 != rcfp_pkg::CH_ZERO);
            end
        end
    end

    assign gnss_set = GW'(val[4:0]) * rcfp_pkg::GNSS_STEP_S;
    assign wave_set = WW'(val[4:0]) * rcfp_pkg::WAVE_STEP_S;

    // GNSS interval limits and min-fix floor, applied in the prep cycle
    always_comb
    begin
        gnss_clamped = gnss_reg;
        if (gnss_reg > rcfp_pkg::GNSS_MAX_S)
            gnss_clamped = rcfp_pkg::GNSS_MAX_S;
        if (gnss_reg < rcfp_pkg::GNSS_MIN_S)
            gnss_clamped = rcfp_pkg::GNSS_MIN_S;
    end

    // count * interval > 21600 is the same as count > 21600 / interval
    assign minfix_m1 = (minfix_reg > FW'(div_quot)) ? FW'(div_quot) : minfix_reg;
    assign minfix_m2 = (minfix_m1 > maxfix_reg) ?
                       ((maxfix_reg != '0) ? maxfix_reg - 1'b1 : '0) : minfix_m1;

    assign div_start = (state_reg == rcfp_pkg::ST_PREP);

    rcfp_div #(
        .NUM_W (GW),
        .Q_W   (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (rcfp_pkg::GNSS_MAX_S),
        .denom (gnss_clamped),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // ---------------------------------------------------------------------
    // Sequencer and byte processing
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        prefix_next    = prefix_reg;
        boot_ok_next   = boot_ok_reg;
        reboot_next    = reboot_reg;
        gnss_next      = gnss_reg;
        wave_next      = wave_reg;
        therm_next     = therm_reg;
        minfix_next    = minfix_reg;
        set_valid_next = set_valid_reg && !set_ready;
        set_item_next  = set_item_reg;

        case (state_reg)
            rcfp_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    // BOOT prefix on the first four bytes
                    if (prefix_reg < 3'd4)
                    begin
                        case (prefix_reg[1:0])
                            2'd0:    if (bt != rcfp_pkg::CH_B) boot_ok_next = 1'b0;
                            2'd1:    if (bt != rcfp_pkg::CH_O) boot_ok_next = 1'b0;
                            2'd2:    if (bt != rcfp_pkg::CH_O) boot_ok_next = 1'b0;
                            default: if (bt != rcfp_pkg::CH_T) boot_ok_next = 1'b0;
                        endcase
                        prefix_next = prefix_reg + 1'b1;
                    end

                    if (fill_reg != 3'd6)
                        fill_next = fill_reg + 1'b1;
                    else if (frame_hit)
                    begin
                        fill_next = '0;
                        if (!val_neg)
                        begin
                            if (win_reg[1] == rcfp_pkg::CH_G && win_reg[2] == rcfp_pkg::CH_F &&
                                win_reg[3] == rcfp_pkg::CH_Q && val <= rcfp_pkg::GNSS_VMAX)
                                gnss_next = gnss_set;
                            if (win_reg[1] == rcfp_pkg::CH_W && win_reg[2] == rcfp_pkg::CH_F &&
                                win_reg[3] == rcfp_pkg::CH_Q && val <= rcfp_pkg::WAVE_VMAX)
                                wave_next = wave_set;
                            if (win_reg[1] == rcfp_pkg::CH_T && win_reg[2] == rcfp_pkg::CH_F &&
                                win_reg[3] == rcfp_pkg::CH_Q && val <= rcfp_pkg::WAVE_VMAX)
                                therm_next = wave_set;
                            if (win_reg[1] == rcfp_pkg::CH_G && win_reg[2] == rcfp_pkg::CH_M &&
                                win_reg[3] == rcfp_pkg::CH_L && FW'(val) <= maxfix_reg)
                                minfix_next = FW'(val);
                        end
                    end
                    // otherwise the window slides and stays at six bytes

                    if (cmd_item.last_byte)
                    begin
                        reboot_next  = boot_ok_next && (prefix_next == 3'd4);
                        fill_next    = '0;
                        prefix_next  = '0;
                        boot_ok_next = 1'b1;
                        state_next   = rcfp_pkg::ST_PREP;
                    end
                end
            end

            rcfp_pkg::ST_PREP:
            begin
                gnss_next = gnss_clamped;
                if (minfix_reg == '0)
                    minfix_next = FW'(1);
                state_next = rcfp_pkg::ST_DIV;
            end

            rcfp_pkg::ST_DIV:
            begin
                if (div_stat.done)
                    state_next = rcfp_pkg::ST_FIN;
            end

            rcfp_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    minfix_next    = minfix_m2;
                    set_valid_next = 1'b1;
                    set_item_next.gnss_interval_s       = gnss_reg;
                    set_item_next.min_fixes_per_message = minfix_m2;
                    set_item_next.wave_interval_s       = wave_reg;
                    set_item_next.thermistor_interval_s = therm_reg;
                    set_item_next.reboot_request        = reboot_reg;
                    state_next = rcfp_pkg::ST_IDLE;
                end
            end

            default:
                state_next = rcfp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcfp_pkg::ST_IDLE;
            fill_reg      <= '0;
            prefix_reg    <= '0;
            boot_ok_reg   <= 1'b1;
            reboot_reg    <= 1'b0;
            gnss_reg      <= rcfp_pkg::GNSS_RST;
            wave_reg      <= rcfp_pkg::WAVE_RST;
            therm_reg     <= rcfp_pkg::THERM_RST;
            minfix_reg    <= rcfp_pkg::MINFIX_RST;
            maxfix_reg    <= rcfp_pkg::MAXFIX_RST;
            set_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            prefix_reg    <= prefix_next;
            boot_ok_reg   <= boot_ok_next;
            reboot_reg    <= reboot_next;
            gnss_reg      <= gnss_next;
            wave_reg      <= wave_next;
            therm_reg     <= therm_next;
            minfix_reg    <= minfix_next;
            set_valid_reg <= set_valid_next;
            if (cfg_valid && cfg_ready)
                maxfix_reg <= cfg_data;
        end
    end

    // window storage: append while filling, slide once full unless a frame closes
    always_ff @(posedge clk)
    begin
        set_item_reg <= set_item_next;
        if (cmd_fire)
        begin
            if (fill_reg != 3'd6)
                win_reg[fill_reg] <= bt;
            else if (!frame_hit)
            begin
                for (int i = 0; i < 5; i++)
                    win_reg[i] <= win_reg[i+1];
                win_reg[5] <= bt;
            end
        end
    end

    assign set_valid = set_valid_reg;
    assign set_item  = set_item_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'd6)
        else $error("window fill count past six");

    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg <= 3'd4)
        else $error("prefix counter past four");

    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == rcfp_pkg::ST_DIV))
        else $error("divider running outside divide state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == rcfp_pkg::ST_DIV))
        else $error("divider finished outside divide state");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(set_valid_reg) |-> $past(state_reg == rcfp_pkg::ST_FIN))
        else $error("settings item raised outside result state");

    a_gnss_limits: assert property (@(posedge clk) disable iff (!rst_n)
        set_valid_reg |-> (set_item_reg.gnss_interval_s >= rcfp_pkg::GNSS_MIN_S) &&
                          (set_item_reg.gnss_interval_s <= rcfp_pkg::GNSS_MAX_S))
        else $error("emitted GNSS interval out of limits");

endmodule

### design/rcfp_div.sv
// ============================================================================
// rcfp_div - iterative restoring divider
// One quotient bit per cycle; quotient must fit in Q_W bits.
// ============================================================================
module rcfp_div #(
    parameter int NUM_W = rcfp_pkg::GNSS_W,
    parameter int Q_W   = rcfp_pkg::QUO_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   numer,
    input  logic [NUM_W-1:0]   denom,
    output logic [Q_W-1:0]     quot,
    output rcfp_pkg::div_stat_t stat
);

    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam int SH_W  = NUM_W + Q_W - 1;

    logic [NUM_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] den_reg,  den_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SH_W-1:0]  den_sh;
    logic             ge;

    assign den_sh = SH_W'(den_reg) << cnt_reg;
    assign ge     = SH_W'(rem_reg) >= den_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer;
            den_next  = denom;
            quot_next = '0;
            cnt_next  = CNT_W'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // trial subtract of the divisor at the current weight
            if (ge)
                rem_next = rem_reg - den_sh[NUM_W-1:0];
            quot_next = {quot_reg[Q_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
